FILE: rtl/sai_pkg.sv
`default_nettype none

package sai_pkg;

	localparam int unsigned DEPTH_DEFAULT = 128;
	localparam int unsigned DATA_W        = 32;
	localparam int unsigned INDEX_W       = 7;
	localparam int unsigned POS_W         = 7;
	localparam int unsigned COUNT_W       = 8;
	localparam int unsigned STATUS_W      = 2;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_READ   = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

	typedef struct packed {
		logic                     ins;
		logic signed [DATA_W-1:0] value;
		logic [INDEX_W-1:0]       idx;
	} sai_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/sai_cell.sv
`default_nettype none

module sai_cell
	import sai_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEFAULT,
	parameter int unsigned IDX   = 0,
	parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
	input  wire logic                     clk,
	input  wire sai_cmd_t                 cmd,
	input  wire logic [CW-1:0]            fill,
	input  wire logic signed [DATA_W-1:0] prev_entry,
	input  wire logic                     prev_g,
	output logic signed [DATA_W-1:0]      entry,
	output logic                          g,
	output logic                          hit,
	output logic [DATA_W-1:0]             rd_data
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned KW = (AW > INDEX_W) ? AW : INDEX_W;

	logic signed [DATA_W-1:0] entry_q;
	logic                     held;
	logic                     rd_sel;

	// cells at or above the fill level act as +infinity
	assign held    = CW'(IDX) < fill;
	assign g       = !held || (cmd.value < entry_q);
	assign hit     = g && !prev_g;
	assign rd_sel  = KW'(cmd.idx) == KW'(IDX);
	assign rd_data = rd_sel ? entry_q : '0;
	assign entry   = entry_q;

	// shift up from the neighbor below, or take the new value at the insert point
	always_ff @(posedge clk) begin
		if (cmd.ins && g) begin
			entry_q <= prev_g ? prev_entry : cmd.value;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sorted_array_insert.sv
`default_nettype none

// Sorted table of signed 32-bit values held in a row of DEPTH cells.
// Command channel: an item (func, value, index) transfers at a rising edge
// with start high and busy low. busy stays low: a new item may start every
// cycle, one item per cycle sustained.
// func insert: value goes in front of the first entry strictly greater than
// it, or at the end; larger entries shift up one cell. A full table rejects
// the insert with status full. func read: returns the entry at index, or
// status range when index is at or beyond the count.
// Result channel: done is high for exactly one cycle with data, position,
// count and status; each item passes through the command capture registers
// and then the output registers, which drive the result ports.
// The receiver cannot stall, so results are never held.
// Timing: every cell compares the new value against its entry in the same
// cycle and takes its neighbor's entry or the value at the next edge; the
// insert position and the read data come from an OR tree over the cells.
// Reset clears the count and the pipeline; entries need no clearing, since
// only entries below the count are ever read.
module sorted_array_insert
	import sai_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic                     func,
	input  wire logic signed [DATA_W-1:0] value,
	input  wire logic [INDEX_W-1:0]       index,
	output logic                          done,
	output logic signed [DATA_W-1:0]      data,
	output logic [POS_W-1:0]              position,
	output logic [COUNT_W-1:0]            count,
	output logic [STATUS_W-1:0]           status
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned IW = (CW > INDEX_W) ? CW : INDEX_W;

	logic                     vld_s1;
	logic                     func_s1;
	logic signed [DATA_W-1:0] value_s1;
	logic [INDEX_W-1:0]       index_s1;

	logic [CW-1:0]            count_q;
	logic                     full;
	logic                     ins_en;
	logic                     rd_ok;
	sai_cmd_t                 cmd;

	logic signed [DATA_W-1:0] entry_w [DEPTH];
	logic                     g_w     [DEPTH];
	logic [DEPTH-1:0]         hit_w;
	logic [DATA_W-1:0]        rd_w    [DEPTH];

	logic [AW-1:0]            pos_enc;
	logic [DATA_W-1:0]        rd_or;
	logic [CW-1:0]            count_nxt;

	logic                     done_q;
	logic signed [DATA_W-1:0] data_q;
	logic [POS_W-1:0]         position_q;
	logic [COUNT_W-1:0]       count_out_q;
	logic [STATUS_W-1:0]      status_q;

	assign busy = 1'b0;

	// command capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			func_s1  <= func;
			value_s1 <= value;
			index_s1 <= index;
		end
	end

	assign full   = count_q == CW'(DEPTH);
	assign ins_en = vld_s1 && (func_s1 == FUNC_INSERT) && !full;
	assign rd_ok  = IW'(index_s1) < IW'(count_q);

	assign cmd.ins   = ins_en;
	assign cmd.value = value_s1;
	assign cmd.idx   = index_s1;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			sai_cell #(.DEPTH(DEPTH), .IDX(i), .CW(CW)) u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.fill       (count_q),
				.prev_entry ('0),
				.prev_g     (1'b0),
				.entry      (entry_w[i]),
				.g          (g_w[i]),
				.hit        (hit_w[i]),
				.rd_data    (rd_w[i])
			);
		end else begin : g_rest
			sai_cell #(.DEPTH(DEPTH), .IDX(i), .CW(CW)) u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.fill       (count_q),
				.prev_entry (entry_w[i-1]),
				.prev_g     (g_w[i-1]),
				.entry      (entry_w[i]),
				.g          (g_w[i]),
				.hit        (hit_w[i]),
				.rd_data    (rd_w[i])
			);
		end
	end

	// one-hot insert point and selected read data, reduced by OR
	always_comb begin
		pos_enc = '0;
		rd_or   = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (hit_w[i]) begin
				pos_enc = pos_enc | AW'(i);
			end
			rd_or = rd_or | rd_w[i];
		end
	end

	assign count_nxt = ins_en ? count_q + CW'(1) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			count_out_q <= COUNT_W'(count_nxt);
			unique case (func_s1)
				FUNC_INSERT: begin
					data_q     <= value_s1;
					position_q <= full ? '0 : POS_W'(pos_enc);
					status_q   <= full ? STATUS_FULL : STATUS_OK;
				end
				FUNC_READ: begin
					data_q     <= rd_ok ? rd_or : '0;
					position_q <= POS_W'(index_s1);
					status_q   <= rd_ok ? STATUS_OK : STATUS_RANGE;
				end
				default: begin
					data_q     <= '0;
					position_q <= '0;
					status_q   <= STATUS_OK;
				end
			endcase
		end
	end

	assign done     = done_q;
	assign data     = data_q;
	assign position = position_q;
	assign count    = count_out_q;
	assign status   = status_q;

	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count above depth");

	a_count_step : assert property (@(posedge clk) disable iff (!arst_n)
		ins_en |=> count_q == CW'($past(count_q) + CW'(1)))
		else $error("insert did not advance fill count");

	a_one_slot : assert property (@(posedge clk) disable iff (!arst_n)
		ins_en |-> $onehot(hit_w))
		else $error("insert point not unique");

	a_one_result : assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |=> done)
		else $error("item gave no result");

endmodule

`default_nettype wire

FILE: test/sorted_array_insert_test.sv
`timescale 1ns / 1ps

module sorted_array_insert_test;
	import sai_pkg::*;

	localparam int unsigned DEPTH = DEPTH_DEFAULT;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned RANDOM_ITEMS = 1625;

	typedef struct {
		logic signed [DATA_W-1:0] data;
		logic [POS_W-1:0]         position;
		logic [COUNT_W-1:0]       count;
		logic [STATUS_W-1:0]      status;
	} table_result_t;

	class sorted_table_tracker;
		logic signed [DATA_W-1:0] model_cells [DEPTH];
		int unsigned              model_count;
		table_result_t            awaited_results [$];
		int unsigned              failures;

		function new();
			model_count = 0;
			failures = 0;
		endfunction

		function int unsigned outstanding();
			return awaited_results.size();
		endfunction

		function void note_item(input logic f, input logic signed [DATA_W-1:0] v,
				input logic [INDEX_W-1:0] idx);
			table_result_t r;
			int unsigned slot;
			if (f == FUNC_INSERT) begin
				if (model_count >= DEPTH) begin
					r.data = v;
					r.position = '0;
					r.status = STATUS_FULL;
				end else begin
					slot = model_count;
					for (int i = 0; i < model_count; i++)
						if (slot == model_count && v < model_cells[i])
							slot = i;
					for (int i = model_count; i > slot; i--)
						model_cells[i] = model_cells[i - 1];
					model_cells[slot] = v;
					model_count++;
					r.data = v;
					r.position = POS_W'(slot);
					r.status = STATUS_OK;
				end
			end else begin
				r.position = idx;
				if (idx >= model_count) begin
					r.data = '0;
					r.status = STATUS_RANGE;
				end else begin
					r.data = model_cells[idx];
					r.status = STATUS_OK;
				end
			end
			r.count = COUNT_W'(model_count);
			awaited_results.push_back(r);
		endfunction

		function void check_result(input logic signed [DATA_W-1:0] d,
				input logic [POS_W-1:0] p, input logic [COUNT_W-1:0] c,
				input logic [STATUS_W-1:0] s);
			table_result_t e;
			if (awaited_results.size() == 0) begin
				$display("%0t unexpected result: data %0d position %0d count %0d status %0d",
					$time, d, p, c, s);
				failures++;
				return;
			end
			e = awaited_results.pop_front();
			if (d !== e.data) begin
				$display("%0t data mismatch: expected %0d actual %0d", $time, e.data, d);
				failures++;
			end
			if (p !== e.position) begin
				$display("%0t position mismatch: expected %0d actual %0d", $time, e.position, p);
				failures++;
			end
			if (c !== e.count) begin
				$display("%0t count mismatch: expected %0d actual %0d", $time, e.count, c);
				failures++;
			end
			if (s !== e.status) begin
				$display("%0t status mismatch: expected %0d actual %0d", $time, e.status, s);
				failures++;
			end
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     func = FUNC_INSERT;
	logic signed [DATA_W-1:0] value = '0;
	logic [INDEX_W-1:0]       index = '0;
	logic                     busy;
	logic                     done;
	logic signed [DATA_W-1:0] data;
	logic [POS_W-1:0]         position;
	logic [COUNT_W-1:0]       count;
	logic [STATUS_W-1:0]      status;

	sorted_table_tracker tracker = new();
	int unsigned quiet_cycles = 0;

	sorted_array_insert #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.value(value),
		.index(index),
		.done(done),
		.data(data),
		.position(position),
		.count(count),
		.status(status)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_result(data, position, count, status);
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_item(input logic f, input logic signed [DATA_W-1:0] v,
			input logic [INDEX_W-1:0] idx);
		start <= 1'b1;
		func <= f;
		value <= v;
		index <= idx;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		tracker.note_item(f, v, idx);
	endtask

	task automatic idle_for(input int unsigned n);
		if (n > 0) begin
			start <= 1'b0;
			func <= 1'($urandom_range(0, 1));
			value <= $urandom;
			index <= INDEX_W'($urandom_range(0, 127));
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		idle_for(1);
		while (tracker.outstanding() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		logic signed [DATA_W-1:0] v;
		case ($urandom_range(0, 7))
			0, 1: v = $urandom_range(0, 6) - 3;
			2: begin
				case ($urandom_range(0, 3))
					0: v = 32'sh8000_0000;
					1: v = 32'sh7fff_ffff;
					2: v = '0;
					default: v = -1;
				endcase
			end
			3: begin
				if (tracker.model_count > 0)
					v = tracker.model_cells[$urandom_range(0, tracker.model_count - 1)];
				else
					v = $urandom;
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic logic [INDEX_W-1:0] pick_index();
		logic [INDEX_W-1:0] idx;
		case ($urandom_range(0, 9))
			0: idx = INDEX_W'($urandom_range(0, 127));
			1: begin
				if (tracker.model_count < DEPTH)
					idx = INDEX_W'(tracker.model_count);
				else
					idx = INDEX_W'($urandom_range(0, 127));
			end
			default: begin
				if (tracker.model_count > 0)
					idx = INDEX_W'($urandom_range(0, tracker.model_count - 1));
				else
					idx = INDEX_W'($urandom_range(0, 127));
			end
		endcase
		return idx;
	endfunction

	initial begin
		int unsigned burst_left;
		logic f;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		idle_for(2);

		// empty table, extremes, equal values, front and end placement
		send_item(FUNC_READ, 32'sh0, 7'd0);
		send_item(FUNC_READ, -1, 7'd127);
		send_item(FUNC_INSERT, 32'sh0, 7'd0);
		send_item(FUNC_INSERT, 32'sh7fff_ffff, 7'd127);
		send_item(FUNC_INSERT, 32'sh8000_0000, 7'd0);
		send_item(FUNC_INSERT, 32'sh0, 7'd127);
		idle_for(3);
		send_item(FUNC_INSERT, -1, 7'd0);
		send_item(FUNC_INSERT, 32'sd5, 7'd0);
		send_item(FUNC_INSERT, 32'sd5, 7'd0);
		send_item(FUNC_INSERT, 32'sh7fff_ffff, 7'd0);
		send_item(FUNC_INSERT, 32'sh8000_0000, 7'd127);
		for (int i = 0; i < 10; i++)
			send_item(FUNC_READ, $urandom, INDEX_W'(i));
		send_item(FUNC_READ, 32'sh0, 7'd10);
		send_item(FUNC_READ, -1, 7'd127);
		drain_results();

		burst_left = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				if ($urandom_range(0, 3) != 0)
					idle_for($urandom_range(1, 10));
			end
			burst_left--;
			if (n == RANDOM_ITEMS / 2)
				drain_results();
			if (tracker.model_count < DEPTH)
				f = ($urandom_range(0, 9) < 7) ? FUNC_INSERT : FUNC_READ;
			else
				f = ($urandom_range(0, 3) == 0) ? FUNC_INSERT : FUNC_READ;
			if (f == FUNC_INSERT)
				send_item(f, pick_value(), INDEX_W'($urandom_range(0, 127)));
			else
				send_item(f, $urandom, pick_index());
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (tracker.failures == 0 && tracker.outstanding() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/sai_pkg.sv
rtl/sai_cell.sv
rtl/sorted_array_insert.sv
test/sorted_array_insert_test.sv
